// ===== src/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared types and fixed constants for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   // Fixed widths of the external fields.
   localparam int PAGE_PORT_BITS  = 16;
   localparam int FRAME_PORT_BITS = 4;
   localparam int FAULT_BITS      = 32;
   localparam int CFG_BITS        = 5;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_ADDR_BITS   = 3;

   // Register map: the word index is address bit 2.
   localparam logic CSR_FRAMES_IN_USE = 1'b0;

   // Reset value of frames_in_use.
   localparam logic [CFG_BITS-1:0] FRAMES_RESET = 5'd16;

   // Saturation value of the fault counter.
   localparam logic [FAULT_BITS-1:0] FAULT_MAX = '1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   // Kind of reference resolved by the lookup.
   typedef enum logic [1:0] {
      OP_HIT,
      OP_FILL,
      OP_REPLACE
   } op_type;

   // Command broadcast from the sequencer to every cell.
   typedef struct packed {
      logic update;   // apply the touch this cycle
      logic age_all;  // every valid frame but the selected one ages, regardless of rank
      logic load;     // selected frame takes the new page and becomes valid
   } cell_cmd_type;

endpackage

// ===== src/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement
// Keeps a row of page frames with recency ranks. Each reference is looked up
// across all frames; hits refresh the frame, misses fill the next empty frame
// or replace the least recently used one. Reports hit, frame, eviction and a
// saturating fault count.
// ----------------------------------------------------------------------------
//
//   Port group   Direction  Handshake            Beat contents
//   req_         in         req_valid/req_ready  page_number
//   rsp_         out        rsp_valid/rsp_ready  hit, frame_index, evicted_valid,
//                                                evicted_page, fault_count
//   APB          in/out     psel/penable/pready  frames_in_use at address 0
//
// An accepted reference passes a lookup state (compare and victim search
// across the cells), then an update state (rank update in every cell).
// The next beat is accepted as the last one commits. Results go to an
// output register; a stalled rsp_ channel holds the update cycle until the
// register frees up. Reset (synchronous) empties all frames, clears the
// fault count and sets frames_in_use to 16.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
   parameter int FRAMES    = 16,
   parameter int PAGE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Reference channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [lrupr_pkg::PAGE_PORT_BITS-1:0]  req_page_number,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_hit,
   output logic [lrupr_pkg::FRAME_PORT_BITS-1:0] rsp_frame_index,
   output logic                                  rsp_evicted_valid,
   output logic [lrupr_pkg::PAGE_PORT_BITS-1:0]  rsp_evicted_page,
   output logic [lrupr_pkg::FAULT_BITS-1:0]      rsp_fault_count,
   // Configuration port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [lrupr_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [lrupr_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [lrupr_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                  pready
);
   import lrupr_pkg::*;

   localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CW = $clog2(FRAMES + 1);

   // Configuration register.
   logic [CFG_BITS-1:0] frames_ff;
   logic                csr_write;

   // Sequencer.
   state_type state_ff, state_in;
   logic      accept;
   logic      commit;

   // Reference and lookup result.
   logic [PAGE_BITS-1:0] page_ff;
   logic [FRAMES-1:0]    sel_ff, sel_in;
   op_type               op_ff, op_in;
   logic [CW-1:0]        fill_ff;
   logic [FAULT_BITS-1:0] faults_ff, faults_in;

   // Cell row.
   logic [FRAMES:0]                  hit_chain;
   logic [FRAMES-1:0]                first_hit;
   logic [FRAMES-1:0]                cell_valid;
   logic [FRAMES-1:0][RW-1:0]        cell_rank;
   logic [FRAMES-1:0][PAGE_BITS-1:0] cell_page;
   logic [FRAMES-1:0]                active;
   logic [FRAMES-1:0]                fill_sel;
   logic [FRAMES-1:0]                victim;
   logic [CW-1:0]                    act;
   cell_cmd_type                     cmd;

   // Update-cycle values.
   logic [RW-1:0]        limit;
   logic [RW-1:0]        frame_idx;
   logic [PAGE_BITS-1:0] ev_page;

   // Output register.
   logic                       rsp_valid_ff;
   logic                       hit_ff;
   logic [FRAME_PORT_BITS-1:0] frame_ff;
   logic                       ev_valid_ff;
   logic [PAGE_PORT_BITS-1:0]  ev_page_ff;
   logic [FAULT_BITS-1:0]      count_ff;

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready & (paddr[2] == CSR_FRAMES_IN_USE);
   assign prdata    = (paddr[2] == CSR_FRAMES_IN_USE) ?
                      CSR_DATA_BITS'(frames_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RESET;
      end else if (csr_write) begin
         frames_ff <= pwdata[CFG_BITS-1:0];
      end
   end

   // Active frame count, clamped to 1..FRAMES.
   always_comb begin
      if (frames_ff == '0) begin
         act = CW'(1);
      end else if (32'(frames_ff) > 32'(FRAMES)) begin
         act = CW'(FRAMES);
      end else begin
         act = CW'(frames_ff);
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   assign commit = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            req_ready = commit;
            if (commit) begin
               state_in = req_valid ? ST_LOOKUP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign accept = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The reference beat is held for the lookup and update cycles.
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= PAGE_BITS'(req_page_number);
      end
   end

   // ------------------------------------------------------------------
   // Cell row
   // ------------------------------------------------------------------
   assign hit_chain[0] = 1'b0;

   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         active[i]   = CW'(i) < act;
         fill_sel[i] = CW'(i) == fill_ff;
      end
   end

   always_comb begin
      cmd.update  = commit;
      cmd.age_all = (op_ff == OP_FILL);
      cmd.load    = (op_ff != OP_HIT);
   end

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      lrupr_cell #(
         .PAGE_BITS (PAGE_BITS),
         .RANK_BITS (RW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .active     (active[i]),
         .page       (page_ff),
         .hit_in     (hit_chain[i]),
         .hit_out    (hit_chain[i+1]),
         .first_hit  (first_hit[i]),
         .cmd        (cmd),
         .sel        (sel_ff[i]),
         .limit      (limit),
         .valid      (cell_valid[i]),
         .rank       (cell_rank[i]),
         .frame_page (cell_page[i])
      );
   end

   lrupr_victim #(
      .FRAMES    (FRAMES),
      .RANK_BITS (RW)
   ) u_victim (
      .cand   (active & cell_valid),
      .ranks  (cell_rank),
      .victim (victim)
   );

   // ------------------------------------------------------------------
   // Lookup: decide hit, fill or replace and latch the chosen frame
   // ------------------------------------------------------------------
   always_comb begin
      if (hit_chain[FRAMES]) begin
         op_in  = OP_HIT;
         sel_in = first_hit;
      end else if (fill_ff < act) begin
         op_in  = OP_FILL;
         sel_in = fill_sel;
      end else begin
         op_in  = OP_REPLACE;
         sel_in = victim;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOKUP) begin
         op_ff  <= op_in;
         sel_ff <= sel_in;
      end
   end

   // ------------------------------------------------------------------
   // Update: gather the chosen frame's rank, index and old page
   // ------------------------------------------------------------------
   always_comb begin
      limit     = '0;
      frame_idx = '0;
      ev_page   = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (sel_ff[i]) begin
            limit     = limit | cell_rank[i];
            frame_idx = frame_idx | RW'(i);
            ev_page   = ev_page | cell_page[i];
         end
      end
   end

   assign faults_in = (faults_ff == FAULT_MAX) ? faults_ff : faults_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         faults_ff <= '0;
      end else if (commit) begin
         if (op_ff == OP_FILL) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (op_ff != OP_HIT) begin
            faults_ff <= faults_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         hit_ff      <= (op_ff == OP_HIT);
         frame_ff    <= FRAME_PORT_BITS'(frame_idx);
         ev_valid_ff <= (op_ff == OP_REPLACE);
         ev_page_ff  <= (op_ff == OP_REPLACE) ? PAGE_PORT_BITS'(ev_page) : '0;
         count_ff    <= (op_ff == OP_HIT) ? faults_ff : faults_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_frame_index   = frame_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_page  = ev_page_ff;
   assign rsp_fault_count   = count_ff;

endmodule

// ===== src/lrupr_cell.sv =====
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one frame (valid bit, page number, recency rank), compares it with
// the referenced page and passes the first-match token to its neighbor.
// ----------------------------------------------------------------------------
module lrupr_cell #(
   parameter int PAGE_BITS = 16,
   parameter int RANK_BITS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       active,
   input  logic [PAGE_BITS-1:0]       page,
   input  logic                       hit_in,
   output logic                       hit_out,
   output logic                       first_hit,
   input  lrupr_pkg::cell_cmd_type    cmd,
   input  logic                       sel,
   input  logic [RANK_BITS-1:0]       limit,
   output logic                       valid,
   output logic [RANK_BITS-1:0]       rank,
   output logic [PAGE_BITS-1:0]       frame_page
);
   import lrupr_pkg::*;

   logic                 valid_ff, valid_in;
   logic [RANK_BITS-1:0] rank_ff, rank_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 match;

   // A match counts only in a valid, active frame; a lower frame that matched
   // already owns the hit.
   assign match     = valid_ff & active & (page_ff == page);
   assign first_hit = match & ~hit_in;
   assign hit_out   = hit_in | match;

   // Touch: the selected frame becomes most recent; younger frames age, or every valid frame on a fill.
   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      page_in  = page_ff;
      if (cmd.update) begin
         if (sel) begin
            rank_in = '0;
            if (cmd.load) begin
               page_in  = page;
               valid_in = 1'b1;
            end
         end else if (valid_ff && (cmd.age_all || (rank_ff < limit))) begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   // Valid bit is control state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Page and rank are only read while the frame is valid.
   always_ff @(posedge clock) begin
      rank_ff <= rank_in;
      page_ff <= page_in;
   end

   assign valid      = valid_ff;
   assign rank       = rank_ff;
   assign frame_page = page_ff;

endmodule

// ===== src/lrupr_victim.sv =====
// ----------------------------------------------------------------------------
// LRU victim finder
// Picks the candidate frame with the greatest recency rank by eliminating
// candidates one rank bit at a time, most significant bit first.
// ----------------------------------------------------------------------------
module lrupr_victim #(
   parameter int FRAMES    = 16,
   parameter int RANK_BITS = 4
) (
   input  logic [FRAMES-1:0]                cand,
   input  logic [FRAMES-1:0][RANK_BITS-1:0] ranks,
   output logic [FRAMES-1:0]                victim
);
   import lrupr_pkg::*;

   logic [FRAMES-1:0] keep;
   logic [FRAMES-1:0] bit_set;

   // Ranks of valid frames are distinct, so one candidate survives.
   always_comb begin
      keep    = cand;
      bit_set = '0;
      for (int b = RANK_BITS - 1; b >= 0; b--) begin
         for (int i = 0; i < FRAMES; i++) begin
            bit_set[i] = keep[i] & ranks[i][b];
         end
         if (|bit_set) begin
            keep = bit_set;
         end
      end
      victim = keep;
   end

endmodule

// ===== src/lrupr_checker.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Watches the ports of the top level and flags behavior that breaks the
// handshake or the meaning of a result beat.
// ----------------------------------------------------------------------------
module lrupr_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic [lrupr_pkg::PAGE_PORT_BITS-1:0]  req_page_number,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  rsp_hit,
   input logic [lrupr_pkg::FRAME_PORT_BITS-1:0] rsp_frame_index,
   input logic                                  rsp_evicted_valid,
   input logic [lrupr_pkg::PAGE_PORT_BITS-1:0]  rsp_evicted_page,
   input logic [lrupr_pkg::FAULT_BITS-1:0]      rsp_fault_count
);
   import lrupr_pkg::*;

   // A stalled result beat keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
      $stable(rsp_frame_index) && $stable(rsp_evicted_valid) &&
      $stable(rsp_evicted_page) && $stable(rsp_fault_count))
      else $error("result beat changed while stalled");

   // After a reference beat is taken, the lookup cycle accepts nothing.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("reference accepted during lookup");

   // Only a fault can evict a page.
   a_evict_on_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted_valid |-> !rsp_hit)
      else $error("eviction reported on a hit");

   // Without an eviction the evicted page reads as zero.
   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == '0)
      else $error("evicted page nonzero without eviction");

   // Reset leaves no result beat pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);

// ===== verif/tb_lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Streams page references through the block and checks every result beat
// against a local recency-order predictor. A directed part covers empty and
// full frame sets, eviction, and changing frames_in_use while frames are
// resident. A random part follows, with working-set traffic under several
// idle and stall patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;
   timeunit 1ns;
   timeprecision 1ps;

   import lrupr_pkg::*;

   localparam int NUM_FRAMES      = 16;
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int REFS_PER_PHASE  = 105;

   localparam logic [CSR_ADDR_BITS-1:0] FRAMES_ADDR = {CSR_FRAMES_IN_USE, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_ADDR  = {~CSR_FRAMES_IN_USE, 2'b00};

   typedef struct {
      logic                       hit;
      logic [FRAME_PORT_BITS-1:0] frame_index;
      logic                       evicted_valid;
      logic [PAGE_PORT_BITS-1:0]  evicted_page;
      logic [FAULT_BITS-1:0]      fault_count;
   } outcome_type;

   // Block ports; every input is driven to a known value from time zero.
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [PAGE_PORT_BITS-1:0]  req_page_number = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_hit;
   logic [FRAME_PORT_BITS-1:0] rsp_frame_index;
   logic                       rsp_evicted_valid;
   logic [PAGE_PORT_BITS-1:0]  rsp_evicted_page;
   logic [FAULT_BITS-1:0]      rsp_fault_count;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]   paddr = '0;
   logic [CSR_DATA_BITS-1:0]   pwdata = '0;
   logic [CSR_DATA_BITS-1:0]   prdata;
   logic                       pready;

   // Predictor state: one copy of every frame plus the configuration.
   logic [PAGE_PORT_BITS-1:0] frame_page [NUM_FRAMES];
   bit                        frame_valid [NUM_FRAMES];
   int                        frame_rank [NUM_FRAMES];
   int                        fill_count;
   logic [FAULT_BITS-1:0]     fault_total;
   logic [CFG_BITS-1:0]       frames_cfg;

   // Traffic bookkeeping.
   logic [PAGE_PORT_BITS-1:0] page_refs [$];
   outcome_type               pending_outcomes [$];
   int                        refs_queued = 0;
   int                        refs_accepted = 0;
   int                        mismatch_count = 0;
   int                        send_idle_pct = 0;
   int                        recv_stall_pct = 0;
   bit                        hold_off_request = 1'b0;
   int                        hold_off_left = 0;
   int                        cycle_count = 0;

   lru_page_replacement dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // Clock generation.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run limit in case the block stops responding.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Number of frames actually managed, after clamping the register.
   function automatic int active_frames();
      if (frames_cfg < 1) return 1;
      if (frames_cfg > NUM_FRAMES) return NUM_FRAMES;
      return int'(frames_cfg);
   endfunction

   // Frame f becomes most recent; every other valid frame younger than limit ages.
   function automatic void touch_frame(input int f, input int limit);
      int i;
      for (i = 0; i < NUM_FRAMES; i++) begin
         if (frame_valid[i] && i != f && frame_rank[i] < limit) frame_rank[i]++;
      end
      frame_rank[f] = 0;
   endfunction

   // Resolve one reference against the frame set and queue the result it causes.
   function automatic void resolve_reference(input logic [PAGE_PORT_BITS-1:0] page);
      outcome_type res;
      int          act;
      int          f;
      int          i;
      bit          found;
      act   = active_frames();
      found = 1'b0;
      f     = 0;
      res.evicted_valid = 1'b0;
      res.evicted_page  = '0;
      // Lowest matching active frame wins when a page is resident twice.
      for (i = act - 1; i >= 0; i--) begin
         if (frame_valid[i] && frame_page[i] == page) begin
            f     = i;
            found = 1'b1;
         end
      end
      if (found) begin
         touch_frame(f, frame_rank[f]);
      end else begin
         if (fill_count < act) begin
            f              = fill_count;
            frame_page[f]  = page;
            frame_valid[f] = 1'b1;
            touch_frame(f, NUM_FRAMES);
            fill_count++;
         end else begin
            // Replace the least recently used active frame.
            for (i = 1; i < act; i++) begin
               if (frame_rank[i] > frame_rank[f]) f = i;
            end
            res.evicted_valid = 1'b1;
            res.evicted_page  = frame_page[f];
            frame_page[f]     = page;
            touch_frame(f, frame_rank[f]);
         end
         if (fault_total != FAULT_MAX) fault_total++;
      end
      res.hit         = found;
      res.frame_index = f[FRAME_PORT_BITS-1:0];
      res.fault_count = fault_total;
      pending_outcomes.push_back(res);
   endfunction

   // Reference driver: offers the next queued page, holding it until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            resolve_reference(req_page_number);
            refs_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (page_refs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid       <= 1'b1;
               req_page_number <= page_refs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each beat and drives rsp_ready, including the hold-off.
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               $error("result beat with no reference outstanding");
               mismatch_count++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit mismatch: expected %0d, actual %0d", want.hit, rsp_hit);
                  mismatch_count++;
               end
               if (rsp_frame_index !== want.frame_index) begin
                  $error("frame_index mismatch: expected %0d, actual %0d",
                         want.frame_index, rsp_frame_index);
                  mismatch_count++;
               end
               if (rsp_evicted_valid !== want.evicted_valid) begin
                  $error("evicted_valid mismatch: expected %0d, actual %0d",
                         want.evicted_valid, rsp_evicted_valid);
                  mismatch_count++;
               end
               if (rsp_evicted_page !== want.evicted_page) begin
                  $error("evicted_page mismatch: expected 0x%h, actual 0x%h",
                         want.evicted_page, rsp_evicted_page);
                  mismatch_count++;
               end
               if (rsp_fault_count !== want.fault_count) begin
                  $error("fault_count mismatch: expected %0d, actual %0d",
                         want.fault_count, rsp_fault_count);
                  mismatch_count++;
               end
            end
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_off_left    = HOLD_OFF_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic push_page(input logic [PAGE_PORT_BITS-1:0] page);
      page_refs.push_back(page);
      refs_queued++;
   endtask

   // Wait until every reference is accepted and answered, plus a short tail.
   task automatic drain();
      while (refs_accepted != refs_queued || pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Register write with a setup phase and an access phase; a write to frames_in_use is read back.
   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == FRAMES_ADDR) begin
         frames_cfg = data[CFG_BITS-1:0];
         @(posedge clock);
         psel  <= 1'b1;
         paddr <= addr;
         @(posedge clock);
         penable <= 1'b1;
         @(negedge clock);
         if (prdata !== CSR_DATA_BITS'(frames_cfg)) begin
            $error("frames_in_use mismatch: expected %0d, actual %0d", frames_cfg, prdata);
            mismatch_count++;
         end
         do @(posedge clock); while (!pready);
         psel    <= 1'b0;
         penable <= 1'b0;
      end
   endtask

   // Working-set traffic: mostly a pool a little larger than the active frames.
   task automatic queue_refs(input int count);
      logic [PAGE_PORT_BITS-1:0] pool [$];
      int                        pick;
      repeat (active_frames() + $urandom_range(4)) pool.push_back(PAGE_PORT_BITS'($urandom()));
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 10) push_page(PAGE_PORT_BITS'($urandom()));
         else if (pick < 13) push_page(pick[0] ? '1 : '0);
         else push_page(pool[$urandom_range(pool.size() - 1)]);
      end
   endtask

   // Main sequence.
   initial begin
      int cfg_plan [8];
      int p;
      cfg_plan = '{16, 1, 8, 31, 0, 3, 20, 12};
      for (p = 0; p < NUM_FRAMES; p++) begin
         frame_page[p]  = '0;
         frame_valid[p] = 1'b0;
         frame_rank[p]  = 0;
      end
      fill_count  = 0;
      fault_total = '0;
      frames_cfg  = FRAMES_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty frames: page zero must miss, since no frame is valid yet.
      push_page(16'h0000);
      push_page(16'hFFFF);
      push_page(16'h0000);
      drain();

      // Four frames: fill the rest, then replace the least recent.
      csr_write(FRAMES_ADDR, 32'd4);
      push_page(16'h1234);
      push_page(16'h8001);
      push_page(16'h4321);
      push_page(16'hFFFF);
      push_page(16'h7FFF);
      drain();

      // Register above range acts as all frames; filling resumes where it stopped.
      csr_write(FRAMES_ADDR, 32'd31);
      push_page(16'h0AAA);
      push_page(16'h5555);
      push_page(16'h1234);
      drain();

      // Register zero acts as one frame; a page held above it misses and is duplicated.
      csr_write(FRAMES_ADDR, 32'd0);
      csr_write(SPARE_ADDR, 32'hFFFF_FFFF);
      push_page(16'h5555);
      push_page(16'h5555);
      push_page(16'h0AAA);
      drain();

      // Back to all frames: the duplicated page resolves to the lowest frame.
      csr_write(FRAMES_ADDR, 32'd16);
      push_page(16'h5555);
      push_page(16'h0AAA);
      drain();

      // Random phases, cycling through the idle patterns.
      for (p = 0; p < 8; p++) begin
         csr_write(SPARE_ADDR, $urandom());
         csr_write(FRAMES_ADDR, ($urandom() & ~32'h1F) | cfg_plan[p]);
         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 80;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 80;
            end
            default: begin
               send_idle_pct  = 22;
               recv_stall_pct = 22;
            end
         endcase
         queue_refs(REFS_PER_PHASE);
         // Long receiver hold-off while references keep coming.
         if (p == 0) begin
            @(negedge clock);
            hold_off_request = 1'b1;
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/lrupr_pkg.sv
src/lrupr_cell.sv
src/lrupr_victim.sv
src/lru_page_replacement.sv
src/lrupr_checker.sv
verif/tb_lru_page_replacement.sv
